### hdl/tme_pkg.sv
`default_nettype none

package tme_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [2:0] {
      OP_ADD        = 3'd0,
      OP_SUB        = 3'd1,
      OP_RIGHT      = 3'd2,
      OP_LEFT       = 3'd3,
      OP_INPUT      = 3'd4,
      OP_OUTPUT     = 3'd5,
      OP_LOOP_START = 3'd6,
      OP_LOOP_END   = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      CSR_VALUE_MIN        = 3'd0,
      CSR_VALUE_MAX        = 3'd1,
      CSR_CELL_COUNT       = 3'd2,
      CSR_VALUE_END_MODE   = 3'd3,
      CSR_POINTER_END_MODE = 3'd4,
      CSR_EOF_MODE         = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      END_ERROR    = 2'd0,
      END_SATURATE = 2'd1,
      END_WRAP     = 2'd2
   } end_mode_type;

   typedef enum logic [2:0] {
      EOF_ZERO      = 3'd0,
      EOF_MIN       = 3'd1,
      EOF_MAX       = 3'd2,
      EOF_MINUS_ONE = 3'd3,
      EOF_KEEP      = 3'd4
   } eof_mode_type;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_VALUE_OVER  = 3'd1,
      ERR_VALUE_UNDER = 3'd2,
      ERR_PTR_OVER    = 3'd3,
      ERR_PTR_UNDER   = 3'd4
   } err_type;

   localparam logic signed [15:0] RESET_VALUE_MIN  = 16'sd0;
   localparam logic signed [15:0] RESET_VALUE_MAX  = 16'sd255;
   localparam logic [15:0]        RESET_CELL_COUNT = 16'd30000;
   localparam logic [1:0]         RESET_VALUE_END  = END_WRAP;
   localparam logic [1:0]         RESET_PTR_END    = END_ERROR;
   localparam logic [2:0]         RESET_EOF_MODE   = EOF_ZERO;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] repeat_count;
      logic [15:0] loop_target;
      logic [7:0]  in_byte;
      logic        in_eof;
   } tme_req_type;

   typedef struct packed {
      logic               take_jump;
      logic [15:0]        jump_target;
      logic               out_valid;
      logic [7:0]         out_byte;
      logic [15:0]        out_repeat;
      logic signed [15:0] cell_value;
      logic [2:0]         error_code;
   } tme_rsp_type;

endpackage

`default_nettype wire

### hdl/tme_mod_unit.sv
`default_nettype none

module tme_mod_unit #(
   parameter int DIVIDEND_W = 19,
   parameter int DIVISOR_W  = 17
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]         divisor,
   output logic                              done,
   output logic [DIVISOR_W-1:0]              result
);

   localparam int STEP_W = $clog2(DIVIDEND_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  fix_ff, fix_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic                  neg_ff, neg_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W-1:0]  result_ff, result_in;

   logic [DIVISOR_W:0] rem_sh;
   logic [DIVISOR_W:0] div_x;
   logic [DIVISOR_W:0] rem_diff;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      div_x    = {1'b0, divisor_ff};
      rem_diff = rem_sh - div_x;

      busy_in    = busy_ff;
      fix_in     = fix_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      neg_in     = neg_ff;
      divisor_in = divisor_ff;
      result_in  = result_ff;

      if (start) begin
         neg_in     = dividend[DIVIDEND_W-1];
         quo_in     = dividend[DIVIDEND_W-1] ? -dividend : dividend;
         divisor_in = divisor;
         rem_in     = '0;
         step_in    = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in  = (rem_sh >= div_x) ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         fix_in    = 1'b0;
         done_in   = 1'b1;
         // non-negative remainder for a negative dividend
         result_in = (neg_ff && (rem_ff != '0)) ? (divisor_ff - rem_ff) : rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      neg_ff     <= neg_in;
      divisor_ff <= divisor_in;
      result_ff  <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

### hdl/tape_machine_execute_unit.sv
// Tape machine execute unit. Takes one run-length coded instruction per item and
// returns one result item. The tape lives in a single memory with a registered read
// port; every op reads the cell at the pointer and cell updates write it back. After
// reset the block sweeps the memory to zero, one cell per cycle, before req_ready
// rises (csr writes are taken during the sweep). From acceptance to a result, loop
// and output ops pass S_EXEC and S_DONE, pointer moves S_EXEC, S_GAP and S_DONE, and
// cell updates S_EXEC, S_WB, S_GAP and S_DONE; S_DONE holds until the previous result
// is taken. A wrapping value or pointer goes through a shared bit-serial remainder
// unit in S_DIV after S_EXEC, on W = max(CELL_WIDTH, 17, clog2(TAPE_DEPTH+1)) + 2 bit
// operands (19 at the defaults). A new item is accepted only in S_IDLE. An error is
// sticky: later items change nothing and only reset clears it.
`default_nettype none

module tape_machine_execute_unit
   import tme_pkg::*;
#(
   parameter int TAPE_DEPTH = 32768,
   parameter int CELL_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire tme_req_type            req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output tme_rsp_type                 rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ADDR_W = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
   localparam int CNT_W  = ($clog2(TAPE_DEPTH + 1) > 17) ? $clog2(TAPE_DEPTH + 1) : 17;
   localparam int BASE_W = (CELL_WIDTH > CNT_W) ? CELL_WIDTH : CNT_W;
   localparam int SW     = BASE_W + 2;

   localparam logic [ADDR_W-1:0]    CLR_LAST = ADDR_W'(TAPE_DEPTH - 1);
   localparam logic [CNT_W-1:0]     DEPTH_N  = CNT_W'(TAPE_DEPTH);
   localparam logic [CNT_W-1:0]     ONE_N    = CNT_W'(1);
   localparam logic signed [SW-1:0] ONE_S    = SW'(1);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_EXEC  = 7'b0000100,
      S_DIV   = 7'b0001000,
      S_WB    = 7'b0010000,
      S_GAP   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic               halted_ff, halted_in;
   logic [2:0]         err_ff, err_in;
   tme_req_type        item_ff, item_in;
   logic [CELL_WIDTH-1:0] wdata_ff, wdata_in;
   logic               res_jump_ff, res_jump_in;
   logic [15:0]        res_target_ff, res_target_in;
   logic               res_ov_ff, res_ov_in;
   logic [7:0]         res_ob_ff, res_ob_in;
   logic [15:0]        res_orep_ff, res_orep_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tme_rsp_type        rsp_ff, rsp_in;

   logic signed [15:0] vmin_ff, vmin_in;
   logic signed [15:0] vmax_ff, vmax_in;
   logic [15:0]        ccount_ff, ccount_in;
   logic [1:0]         vmode_ff, vmode_in;
   logic [1:0]         pmode_ff, pmode_in;
   logic [2:0]         eofm_ff, eofm_in;

   logic [CELL_WIDTH-1:0] tape_mem [TAPE_DEPTH];
   logic [CELL_WIDTH-1:0] mem_rdata_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [CELL_WIDTH-1:0] mem_wdata;

   logic                 div_start;
   logic signed [SW-1:0] div_dividend;
   logic [CNT_W-1:0]     div_divisor;
   logic                 div_done;
   logic [CNT_W-1:0]     div_result;

   logic signed [15:0]   hi16;
   logic signed [SW-1:0] lo_s, hi_s, span_s, n_s, cell_s, cnt_s, p_s;
   logic signed [SW-1:0] val_v, ptr_v, val_d, r_s, val_wrap;
   logic [CNT_W-1:0]     cc_x, n_w;
   logic                 is_add, is_right, is_value_op, val_over, ptr_over;
   logic [CELL_WIDTH-1:0] in_v;

   tme_mod_unit #(
      .DIVIDEND_W(SW),
      .DIVISOR_W (CNT_W)
   ) u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .result  (div_result)
   );

   // operands and range checks
   always_comb begin
      hi16   = (vmax_ff < vmin_ff) ? vmin_ff : vmax_ff;
      lo_s   = {{(SW-16){vmin_ff[15]}}, vmin_ff};
      hi_s   = {{(SW-16){hi16[15]}}, hi16};
      span_s = hi_s - lo_s + ONE_S;
      cc_x   = {{(CNT_W-16){1'b0}}, ccount_ff};
      if (cc_x == '0) begin
         n_w = ONE_N;
      end else if (cc_x > DEPTH_N) begin
         n_w = DEPTH_N;
      end else begin
         n_w = cc_x;
      end
      n_s    = {{(SW-CNT_W){1'b0}}, n_w};
      cell_s = {{(SW-CELL_WIDTH){mem_rdata_ff[CELL_WIDTH-1]}}, mem_rdata_ff};
      cnt_s  = {{(SW-16){1'b0}}, item_ff.repeat_count};
      p_s    = {{(SW-ADDR_W){1'b0}}, ptr_ff};

      is_add      = (item_ff.mode == OP_ADD);
      is_right    = (item_ff.mode == OP_RIGHT);
      is_value_op = (item_ff.mode == OP_ADD) || (item_ff.mode == OP_SUB);

      val_v    = is_add ? (cell_s + cnt_s) : (cell_s - cnt_s);
      val_over = is_add ? (val_v > hi_s) : (val_v < lo_s);
      val_d    = val_v - lo_s;
      ptr_v    = is_right ? (p_s + cnt_s) : (p_s - cnt_s);
      ptr_over = is_right ? (ptr_v > (n_s - ONE_S)) : ptr_v[SW-1];

      div_dividend = is_value_op ? val_d : ptr_v;
      div_divisor  = is_value_op ? span_s[CNT_W-1:0] : n_w;
      r_s          = {{(SW-CNT_W){1'b0}}, div_result};
      val_wrap     = r_s + lo_s;

      if (!item_ff.in_eof) begin
         in_v = {{(CELL_WIDTH-8){1'b0}}, item_ff.in_byte};
      end else begin
         case (eofm_ff)
            EOF_ZERO:      in_v = '0;
            EOF_MIN:       in_v = lo_s[CELL_WIDTH-1:0];
            EOF_MAX:       in_v = hi_s[CELL_WIDTH-1:0];
            EOF_MINUS_ONE: in_v = '1;
            default:       in_v = mem_rdata_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      ptr_in        = ptr_ff;
      halted_in     = halted_ff;
      err_in        = err_ff;
      item_in       = item_ff;
      wdata_in      = wdata_ff;
      res_jump_in   = res_jump_ff;
      res_target_in = res_target_ff;
      res_ov_in     = res_ov_ff;
      res_ob_in     = res_ob_ff;
      res_orep_in   = res_orep_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mem_we        = 1'b0;
      div_start     = 1'b0;

      vmin_in   = vmin_ff;
      vmax_in   = vmax_ff;
      ccount_in = ccount_ff;
      vmode_in  = vmode_ff;
      pmode_in  = pmode_ff;
      eofm_in   = eofm_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_VALUE_MIN:        vmin_in   = csr_data;
            CSR_VALUE_MAX:        vmax_in   = csr_data;
            CSR_CELL_COUNT:       ccount_in = csr_data;
            CSR_VALUE_END_MODE:   vmode_in  = csr_data[1:0];
            CSR_POINTER_END_MODE: pmode_in  = csr_data[1:0];
            CSR_EOF_MODE:         eofm_in   = csr_data[2:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_jump_in   = 1'b0;
            res_target_in = '0;
            res_ov_in     = 1'b0;
            res_ob_in     = '0;
            res_orep_in   = '0;
            state_in      = S_DONE;
            if (!halted_ff) begin
               case (item_ff.mode)
                  OP_ADD, OP_SUB: begin
                     if (!val_over) begin
                        wdata_in = val_v[CELL_WIDTH-1:0];
                        state_in = S_WB;
                     end else begin
                        case (vmode_ff)
                           END_SATURATE: begin
                              wdata_in = is_add ? hi_s[CELL_WIDTH-1:0] : lo_s[CELL_WIDTH-1:0];
                              state_in = S_WB;
                           end
                           END_WRAP: begin
                              div_start = 1'b1;
                              state_in  = S_DIV;
                           end
                           default: begin
                              err_in    = is_add ? ERR_VALUE_OVER : ERR_VALUE_UNDER;
                              halted_in = 1'b1;
                           end
                        endcase
                     end
                  end
                  OP_RIGHT, OP_LEFT: begin
                     if (!ptr_over) begin
                        ptr_in   = ptr_v[ADDR_W-1:0];
                        state_in = S_GAP;
                     end else begin
                        case (pmode_ff)
                           END_SATURATE: begin
                              ptr_in   = is_right ? n_s[ADDR_W-1:0] - 1'b1 : '0;
                              state_in = S_GAP;
                           end
                           END_WRAP: begin
                              div_start = 1'b1;
                              state_in  = S_DIV;
                           end
                           default: begin
                              err_in    = is_right ? ERR_PTR_OVER : ERR_PTR_UNDER;
                              halted_in = 1'b1;
                           end
                        endcase
                     end
                  end
                  OP_INPUT: begin
                     if (item_ff.repeat_count != '0) begin
                        wdata_in = in_v;
                        state_in = S_WB;
                     end
                  end
                  OP_OUTPUT: begin
                     if (item_ff.repeat_count != '0) begin
                        res_ov_in   = 1'b1;
                        res_ob_in   = mem_rdata_ff[7:0];
                        res_orep_in = item_ff.repeat_count;
                     end
                  end
                  OP_LOOP_START: begin
                     if (mem_rdata_ff == '0) begin
                        res_jump_in   = 1'b1;
                        res_target_in = item_ff.loop_target;
                     end
                  end
                  default: begin
                     if (mem_rdata_ff != '0) begin
                        res_jump_in   = 1'b1;
                        res_target_in = item_ff.loop_target;
                     end
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (is_value_op) begin
                  wdata_in = val_wrap[CELL_WIDTH-1:0];
                  state_in = S_WB;
               end else begin
                  ptr_in   = div_result[ADDR_W-1:0];
                  state_in = S_GAP;
               end
            end
         end
         S_WB: begin
            mem_we   = 1'b1;
            state_in = S_GAP;
         end
         S_GAP: begin
            // read of the updated cell lands at the end of this cycle
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.take_jump   = res_jump_ff;
               rsp_in.jump_target = res_target_ff;
               rsp_in.out_valid   = res_ov_ff;
               rsp_in.out_byte    = res_ob_ff;
               rsp_in.out_repeat  = res_orep_ff;
               rsp_in.cell_value  = cell_s[15:0];
               rsp_in.error_code  = err_ff;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign mem_waddr = (state_ff == S_CLEAR) ? clr_ff : ptr_ff;
   assign mem_wdata = (state_ff == S_CLEAR) ? '0 : wdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tape_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= tape_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ptr_ff       <= '0;
         halted_ff    <= 1'b0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
         vmin_ff      <= RESET_VALUE_MIN;
         vmax_ff      <= RESET_VALUE_MAX;
         ccount_ff    <= RESET_CELL_COUNT;
         vmode_ff     <= RESET_VALUE_END;
         pmode_ff     <= RESET_PTR_END;
         eofm_ff      <= RESET_EOF_MODE;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ptr_ff       <= ptr_in;
         halted_ff    <= halted_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         vmin_ff      <= vmin_in;
         vmax_ff      <= vmax_in;
         ccount_ff    <= ccount_in;
         vmode_ff     <= vmode_in;
         pmode_ff     <= pmode_in;
         eofm_ff      <= eofm_in;
      end
      item_ff       <= item_in;
      wdata_ff      <= wdata_in;
      res_jump_ff   <= res_jump_in;
      res_target_ff <= res_target_in;
      res_ov_ff     <= res_ov_in;
      res_ob_ff     <= res_ob_in;
      res_orep_ff   <= res_orep_in;
      rsp_ff        <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tme_pkg::*;

   localparam int TAPE_CELLS    = 32768;
   localparam int SETTLE_CYCLES = 4;

   localparam logic [1:0] END_RESERVED = 2'd3;
   localparam logic [2:0] EOF_RESERVED = 3'd7;

   typedef struct packed {
      logic          is_write;
      csr_index_type csr_sel;
      logic [15:0]   csr_value;
      tme_req_type   ins;
   } step_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   tme_req_type            req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   tme_rsp_type            rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   step_type    pending[$];
   tme_rsp_type results_due[$];
   int          outstanding = 0;
   int          items_taken = 0;
   int          quiet       = 0;
   int          mismatches  = 0;
   wire         steady      = (items_taken >= 150) && (items_taken < 250);

   // shadow of the tape machine
   logic signed [15:0] tape_cells [0:TAPE_CELLS-1];
   int                 head;
   logic               stopped;
   err_type            sticky_err;
   logic signed [15:0] cfg_min;
   logic signed [15:0] cfg_max;
   logic [15:0]        cfg_count;
   logic [1:0]         cfg_value_end;
   logic [1:0]         cfg_ptr_end;
   logic [2:0]         cfg_eof;

   tape_machine_execute_unit #(
      .TAPE_DEPTH(TAPE_CELLS),
      .CELL_WIDTH(16)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_machine();
      for (int i = 0; i < TAPE_CELLS; i++) tape_cells[i] = '0;
      head          = 0;
      stopped       = 1'b0;
      sticky_err    = ERR_NONE;
      cfg_min       = RESET_VALUE_MIN;
      cfg_max       = RESET_VALUE_MAX;
      cfg_count     = RESET_CELL_COUNT;
      cfg_value_end = RESET_VALUE_END;
      cfg_ptr_end   = RESET_PTR_END;
      cfg_eof       = RESET_EOF_MODE;
   endfunction

   function automatic void write_setting(logic [2:0] sel, logic [15:0] value);
      case (csr_index_type'(sel))
         CSR_VALUE_MIN:        cfg_min = value;
         CSR_VALUE_MAX:        cfg_max = value;
         CSR_CELL_COUNT:       cfg_count = value;
         CSR_VALUE_END_MODE:   cfg_value_end = value[1:0];
         CSR_POINTER_END_MODE: cfg_ptr_end = value[1:0];
         CSR_EOF_MODE:         cfg_eof = value[2:0];
         default: ;
      endcase
   endfunction

   function automatic longint wrap_into(longint value, longint lo, longint span);
      longint r;
      r = (value - lo) % span;
      if (r < 0) r += span;
      return r + lo;
   endfunction

   function automatic void execute_instruction(input tme_req_type ins, output tme_rsp_type res);
      longint      lo, hi, cells_used, cur_val, p, v, cnt;
      logic [14:0] slot;
      res        = '0;
      lo         = cfg_min;
      hi         = (cfg_max < cfg_min) ? cfg_min : cfg_max;
      cells_used = (cfg_count == 16'd0) ? 1 : cfg_count;
      if (cells_used > TAPE_CELLS) cells_used = TAPE_CELLS;
      slot    = head[14:0];
      cur_val = tape_cells[slot];
      p       = head;
      cnt     = ins.repeat_count;
      if (!stopped) begin
         case (op_type'(ins.mode))
            OP_ADD, OP_SUB: begin
               v = (ins.mode == OP_ADD) ? cur_val + cnt : cur_val - cnt;
               if ((ins.mode == OP_ADD && v > hi) || (ins.mode == OP_SUB && v < lo)) begin
                  if (cfg_value_end == END_SATURATE) begin
                     v = (ins.mode == OP_ADD) ? hi : lo;
                  end else if (cfg_value_end == END_WRAP) begin
                     v = wrap_into(v, lo, hi - lo + 1);
                  end else begin
                     sticky_err = (ins.mode == OP_ADD) ? ERR_VALUE_OVER : ERR_VALUE_UNDER;
                     stopped    = 1'b1;
                     v          = cur_val;
                  end
               end
               tape_cells[slot] = v[15:0];
            end
            OP_RIGHT, OP_LEFT: begin
               v = (ins.mode == OP_RIGHT) ? p + cnt : p - cnt;
               if ((ins.mode == OP_RIGHT && v > cells_used - 1) || (ins.mode == OP_LEFT && v < 0))
               begin
                  if (cfg_ptr_end == END_SATURATE) begin
                     v = (ins.mode == OP_RIGHT) ? cells_used - 1 : 0;
                  end else if (cfg_ptr_end == END_WRAP) begin
                     v = wrap_into(v, 0, cells_used);
                  end else begin
                     sticky_err = (ins.mode == OP_RIGHT) ? ERR_PTR_OVER : ERR_PTR_UNDER;
                     stopped    = 1'b1;
                     v          = p;
                  end
               end
               head = int'(v);
            end
            OP_INPUT: begin
               if (cnt != 0) begin
                  v = cur_val;
                  if (!ins.in_eof) begin
                     v = ins.in_byte;
                  end else begin
                     case (cfg_eof)
                        EOF_ZERO:      v = 0;
                        EOF_MIN:       v = lo;
                        EOF_MAX:       v = hi;
                        EOF_MINUS_ONE: v = -1;
                        default: ;
                     endcase
                  end
                  tape_cells[slot] = v[15:0];
               end
            end
            OP_OUTPUT: begin
               if (cnt != 0) begin
                  res.out_valid  = 1'b1;
                  res.out_byte   = cur_val[7:0];
                  res.out_repeat = ins.repeat_count;
               end
            end
            OP_LOOP_START: begin
               if (cur_val == 0) begin
                  res.take_jump   = 1'b1;
                  res.jump_target = ins.loop_target;
               end
            end
            default: begin
               if (cur_val != 0) begin
                  res.take_jump   = 1'b1;
                  res.jump_target = ins.loop_target;
               end
            end
         endcase
      end
      res.cell_value = tape_cells[head[14:0]];
      res.error_code = sticky_err;
   endfunction

   function automatic string rsp_text(tme_rsp_type r);
      return $sformatf("jump %0b tgt %h out %0b byte %h rep %0d cell %0d err %0d",
                       r.take_jump, r.jump_target, r.out_valid, r.out_byte, r.out_repeat,
                       r.cell_value, r.error_code);
   endfunction

   function automatic void queue_instruction(op_type op, logic [15:0] cnt,
                                             logic [15:0] target = '0, logic [7:0] byt = '0,
                                             logic eof = 1'b0);
      step_type s;
      s                  = '0;
      s.ins.mode         = op;
      s.ins.repeat_count = cnt;
      s.ins.loop_target  = target;
      s.ins.in_byte      = byt;
      s.ins.in_eof       = eof;
      pending.push_back(s);
   endfunction

   function automatic void queue_write(csr_index_type sel, logic [15:0] value);
      step_type s;
      s           = '0;
      s.is_write  = 1'b1;
      s.csr_sel   = sel;
      s.csr_value = value;
      pending.push_back(s);
   endfunction

   function automatic void queue_settings(logic [15:0] lo, logic [15:0] hi, logic [15:0] cells,
                                          logic [1:0] value_end, logic [1:0] ptr_end,
                                          logic [2:0] eof);
      queue_write(CSR_VALUE_MIN, lo);
      queue_write(CSR_VALUE_MAX, hi);
      queue_write(CSR_CELL_COUNT, cells);
      queue_write(CSR_VALUE_END_MODE, {14'd0, value_end});
      queue_write(CSR_POINTER_END_MODE, {14'd0, ptr_end});
      queue_write(CSR_EOF_MODE, {13'd0, eof});
   endfunction

   function automatic void queue_random(int count);
      step_type s;
      int       pick;
      for (int i = 0; i < count; i++) begin
         s                 = '0;
         s.ins.loop_target = 16'($urandom_range(16'hFFFF));
         s.ins.in_byte     = 8'($urandom_range(255));
         s.ins.in_eof      = ($urandom_range(3) == 0);
         pick              = $urandom_range(99);
         if (pick < 30)      s.ins.mode = $urandom_range(1) ? OP_ADD : OP_SUB;
         else if (pick < 55) s.ins.mode = $urandom_range(1) ? OP_RIGHT : OP_LEFT;
         else if (pick < 65) s.ins.mode = OP_INPUT;
         else if (pick < 75) s.ins.mode = OP_OUTPUT;
         else                s.ins.mode = $urandom_range(1) ? OP_LOOP_START : OP_LOOP_END;
         case ($urandom_range(9))
            0:       s.ins.repeat_count = '0;
            1:       s.ins.repeat_count = 16'($urandom_range(16'hFFFF));
            2:       s.ins.repeat_count = 16'hFFFF;
            3:       s.ins.repeat_count = 16'($urandom_range(20, 400));
            default: s.ins.repeat_count = 16'($urandom_range(1, 6));
         endcase
         pending.push_back(s);
      end
   endfunction

   function automatic logic [15:0] pick_bound();
      case ($urandom_range(4))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'($urandom_range(40)) - 16'd20;
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   function automatic logic [15:0] pick_count();
      case ($urandom_range(6))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'($urandom_range(2, 12));
         3:       return 16'd32768;
         4:       return 16'hFFFF;
         5:       return 16'($urandom_range(30000, 32767));
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   // request and config driver
   always @(posedge clock) begin : drive
      step_type nxt;
      logic     go_req;
      logic     go_csr;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         quiet     <= 0;
      end else begin
         quiet <= (outstanding == 0 && !req_valid) ? quiet + 1 : 0;
         if (!(req_valid && !req_ready) && !(csr_valid && !csr_ready)) begin
            go_req = 1'b0;
            go_csr = 1'b0;
            nxt    = '0;
            if (pending.size() != 0) begin
               nxt = pending[0];
               if (nxt.is_write) go_csr = !req_valid && quiet >= SETTLE_CYCLES;
               else              go_req = steady || ($urandom_range(99) >= 37);
               if (go_req || go_csr) void'(pending.pop_front());
            end
            req_valid <= go_req;
            csr_valid <= go_csr;
            if (go_req) req_data <= nxt.ins;
            if (go_csr) begin
               csr_index <= nxt.csr_sel;
               csr_data  <= nxt.csr_value;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : watch
      tme_rsp_type want;
      tme_rsp_type predicted;
      if (reset) begin
         clear_machine();
         rsp_ready   <= 1'b0;
         outstanding <= 0;
         items_taken <= 0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 37);
         if (csr_valid && csr_ready) write_setting(csr_index, csr_data);
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result: %s", rsp_text(rsp_data));
            end else begin
               want = results_due.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %s, got %s", rsp_text(want), rsp_text(rsp_data));
               end
            end
         end
         if (req_valid && req_ready) begin
            execute_instruction(req_data, predicted);
            results_due.push_back(predicted);
            items_taken <= items_taken + 1;
         end
         outstanding <= results_due.size();
      end
   end

   initial begin : stimulus
      logic [15:0] lo_pick;
      logic [15:0] hi_pick;
      // reset settings: range 0..255 wrapping, pointer errors, eof gives zero
      queue_instruction(OP_LOOP_START, 16'd1, 16'hFFFF);
      queue_instruction(OP_LOOP_END, 16'd1, 16'hFFFF);
      queue_instruction(OP_OUTPUT, 16'd0);
      queue_instruction(OP_ADD, 16'd255);
      queue_instruction(OP_OUTPUT, 16'hFFFF);
      queue_instruction(OP_ADD, 16'd1);
      queue_instruction(OP_SUB, 16'd1);
      queue_instruction(OP_ADD, 16'hFFFF);
      queue_instruction(OP_LOOP_END, 16'd1, 16'h8001);
      queue_instruction(OP_INPUT, 16'd3, '0, 8'hA5);
      queue_instruction(OP_INPUT, 16'd0, '0, 8'h5A);
      queue_instruction(OP_INPUT, 16'd1, '0, 8'hFF, 1'b1);
      queue_instruction(OP_RIGHT, 16'd29999);
      queue_instruction(OP_INPUT, 16'd1, '0, 8'hFF);
      queue_instruction(OP_LEFT, 16'd29999);
      queue_instruction(OP_SUB, 16'hFFFF);
      queue_write(CSR_POINTER_END_MODE, {14'd0, END_SATURATE});
      queue_instruction(OP_RIGHT, 16'hFFFF);
      queue_instruction(OP_LEFT, 16'hFFFF);
      queue_settings(16'h8000, 16'h7FFF, 16'd30000, END_SATURATE, END_SATURATE, EOF_MIN);
      queue_instruction(OP_ADD, 16'hFFFF);
      queue_instruction(OP_SUB, 16'hFFFF);
      queue_instruction(OP_INPUT, 16'd1, '0, 8'h00, 1'b1);
      queue_write(CSR_EOF_MODE, {13'd0, EOF_MAX});
      queue_instruction(OP_INPUT, 16'd1, '0, 8'h00, 1'b1);
      queue_write(CSR_EOF_MODE, {13'd0, EOF_MINUS_ONE});
      queue_instruction(OP_INPUT, 16'd1, '0, 8'h00, 1'b1);
      queue_write(CSR_EOF_MODE, {13'd0, EOF_KEEP});
      queue_instruction(OP_INPUT, 16'd1, '0, 8'h33, 1'b1);
      queue_write(CSR_EOF_MODE, {13'd0, EOF_RESERVED});
      queue_instruction(OP_INPUT, 16'd1, '0, 8'h33, 1'b1);

      // full range, oversized cell count
      queue_settings(16'h8000, 16'h7FFF, 16'hFFFF, END_WRAP, END_WRAP, EOF_RESERVED);
      queue_random(50);
      // max below min, zero cell count
      queue_settings(16'h7FFF, 16'h8000, 16'd0, END_SATURATE, END_WRAP, EOF_ZERO);
      queue_random(50);
      for (int phase = 0; phase < 9; phase++) begin
         lo_pick = pick_bound();
         hi_pick = $urandom_range(1) ? lo_pick + 16'($urandom_range(300)) : pick_bound();
         queue_settings(lo_pick, hi_pick, pick_count(),
                        $urandom_range(1) ? END_SATURATE : END_WRAP,
                        $urandom_range(1) ? END_SATURATE : END_WRAP,
                        3'($urandom_range(7)));
         queue_random(50);
      end

      // error modes last, the block stays halted afterwards
      queue_settings(-16'sd100, 16'sd100, pick_count(),
                     $urandom_range(1) ? END_ERROR : END_RESERVED,
                     $urandom_range(1) ? END_ERROR : END_RESERVED,
                     3'($urandom_range(7)));
      queue_random(10);
      case ($urandom_range(3))
         0:       queue_instruction(OP_ADD, 16'hFFFF);
         1:       queue_instruction(OP_SUB, 16'hFFFF);
         2:       queue_instruction(OP_RIGHT, 16'hFFFF);
         default: queue_instruction(OP_LEFT, 16'hFFFF);
      endcase
      queue_random(15);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (pending.size() != 0 || req_valid || csr_valid || results_due.size() != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);
      if (mismatches == 0 && results_due.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
